/* src/c8rab_pkg.sv */
// ----------------------------------------------------------------------------
// c8rab_pkg
// Shared types, opcode codes and constants of the CHIP-8 execute unit.
// ----------------------------------------------------------------------------
package c8rab_pkg;

	localparam int STACK_DEPTH_DEF = 16;
	localparam int NUM_REGS        = 16;
	localparam int PC_W            = 12;
	localparam int DATA_W          = 8;
	localparam int IDX_W           = 4;
	localparam int INSTR_W         = 16;

	localparam logic [PC_W-1:0]    PC_RESET  = 12'h200;
	localparam logic [PC_W-1:0]    PC_STEP   = 12'h002;
	localparam logic [PC_W-1:0]    PC_SKIP   = 12'h004;
	localparam logic [IDX_W-1:0]   VF_IDX    = 4'hF;
	localparam logic [INSTR_W-1:0] INSTR_CLS = 16'h00E0;
	localparam logic [INSTR_W-1:0] INSTR_RET = 16'h00EE;
	localparam logic [3:0]         SE_REG_SUB = 4'h0;

	// Top nibble of the opcode
	typedef enum logic [3:0] {
		OP_SYS     = 4'h0,
		OP_JP      = 4'h1,
		OP_CALL    = 4'h2,
		OP_SE_IMM  = 4'h3,
		OP_SNE_IMM = 4'h4,
		OP_SE_REG  = 4'h5,
		OP_LD_IMM  = 4'h6,
		OP_ADD_IMM = 4'h7,
		OP_ALU     = 4'h8
	} op_class_t;

	// Low nibble of 8xyN
	typedef enum logic [3:0] {
		ALU_LD  = 4'h0,
		ALU_OR  = 4'h1,
		ALU_AND = 4'h2,
		ALU_XOR = 4'h3,
		ALU_ADD = 4'h4,
		ALU_SUB = 4'h5,
		ALU_SHR = 4'h6
	} alu_op_t;

	typedef struct packed {
		logic [PC_W-1:0]   next_pc;
		logic              clear_screen;
		logic              unhandled;
		logic              stack_fault;
		logic              reg_written;
		logic [IDX_W-1:0]  reg_index;
		logic [DATA_W-1:0] reg_value;
		logic              flag_written;
		logic              flag_value;
	} result_t;

	typedef struct packed {
		logic [INSTR_W-1:0] instr;
		logic [PC_W-1:0]    pc;
		logic [DATA_W-1:0]  vx;
		logic [DATA_W-1:0]  vy;
		logic [PC_W-1:0]    ret_addr;
		logic               stk_full;
		logic               stk_empty;
	} exec_in_t;

	typedef struct packed {
		result_t         res;
		logic            push;
		logic            pop;
		logic [PC_W-1:0] link;
	} exec_out_t;

endpackage

/* src/c8rab_if.sv */
// ----------------------------------------------------------------------------
// c8rab stream interfaces
// Valid/ready channels for instruction words and result words.
// ----------------------------------------------------------------------------
interface c8rab_instr_if;
	logic        valid;
	logic        ready;
	logic [15:0] instruction;

	modport source (output valid, output instruction, input ready);
	modport sink (input valid, input instruction, output ready);
endinterface

interface c8rab_result_if;
	logic        valid;
	logic        ready;
	logic [11:0] next_pc;
	logic        clear_screen;
	logic        unhandled;
	logic        stack_fault;
	logic        reg_written;
	logic [3:0]  reg_index;
	logic [7:0]  reg_value;
	logic        flag_written;
	logic        flag_value;

	modport source (
		output valid, output next_pc, output clear_screen, output unhandled,
		output stack_fault, output reg_written, output reg_index, output reg_value,
		output flag_written, output flag_value, input ready
	);
	modport sink (
		input valid, input next_pc, input clear_screen, input unhandled,
		input stack_fault, input reg_written, input reg_index, input reg_value,
		input flag_written, input flag_value, output ready
	);
endinterface

/* src/chip8_register_alu_branch_unit.sv */
// ----------------------------------------------------------------------------
// chip8_register_alu_branch_unit
// CHIP-8 execute stage: register file, ALU, branches and return stack.
// ----------------------------------------------------------------------------
// Takes one 16-bit CHIP-8 instruction word per cycle while the result port
// is not stalled, and returns one result word per instruction, in order. An
// accepted word reads Vx, Vy and the top of the return stack from synchronous
// memories into stage 1 at the accepting edge; the edge at which stage 1
// advances executes it, writes back the register file, VF, PC and stack,
// and loads the result register that drives the result port.
// Sustained rate is one word per cycle while result.ready stays high; a
// stalled result port holds the word in stage 1 and then drops instr.ready.
// A write-back that lands on the same edge as the next word's read is
// forwarded through a registered bypass, so back-to-back dependent words
// need no bubble. Supported: 00E0, 00EE, 0nnn, 1nnn, 2nnn, 3xkk, 4xkk, 5xy0,
// 6xkk, 7xkk, 8xy0..8xy6; anything else is flagged unhandled and steps PC by
// two. Calls with a full stack and returns with an empty stack raise
// stack_fault and leave the stack alone. PC resets to 0x200, all registers
// to zero; no init sweep is needed after reset.
module chip8_register_alu_branch_unit
	import c8rab_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	c8rab_instr_if.sink           instr,
	c8rab_result_if.source        result
);

	localparam int SP_W   = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

	// Register file V0..VE lives in memory; VF is a flop so a flag and a
	// Vx write can retire in the same cycle through one write port.
	logic [DATA_W-1:0] reg_mem [NUM_REGS];
	logic [PC_W-1:0]   stk_mem [STACK_DEPTH];

	logic [NUM_REGS-1:0] reg_vld_q;
	logic [DATA_W-1:0]   vf_q;
	logic [PC_W-1:0]     pc_q;
	logic [SP_W-1:0]     sp_q;
	logic                s1_valid_q;
	logic                out_valid_q;
	result_t             res_q;

	// Stage 1 payload: word plus registered memory reads and bypass info
	logic [INSTR_W-1:0]  instr_s1;
	logic [DATA_W-1:0]   vx_mem_s1, vy_mem_s1;
	logic                vld_x_s1, vld_y_s1;
	logic                byp_x_s1, byp_y_s1;
	logic [DATA_W-1:0]   byp_data_s1;
	logic [PC_W-1:0]     ret_mem_s1;
	logic                byp_ret_s1;
	logic [PC_W-1:0]     byp_ret_data_s1;

	logic                accept;
	logic                s1_adv;
	exec_in_t            ei;
	exec_out_t           eo;

	logic [IDX_W-1:0]    rd_x, rd_y;
	logic [IDX_W-1:0]    x_s1, y_s1;
	logic                reg_we;
	logic                vf_we;
	logic                stk_we;
	logic [ADDR_W-1:0]   stk_waddr;
	logic [ADDR_W-1:0]   stk_raddr;
	logic [SP_W-1:0]     sp_nxt;
	logic [SP_W-1:0]     sp_eff;
	logic [SP_W-1:0]     sp_eff_m1;

	// ---------------- handshake ----------------
	assign s1_adv      = s1_valid_q && (!out_valid_q || result.ready);
	assign instr.ready = !s1_valid_q || s1_adv;
	assign accept      = instr.valid && instr.ready;

	assign rd_x = instr.instruction[11:8];
	assign rd_y = instr.instruction[7:4];
	assign x_s1 = instr_s1[11:8];
	assign y_s1 = instr_s1[7:4];

	// ---------------- operand select ----------------
	// VF always comes from its flop; others take the bypass first, then
	// the memory word if that entry has been written since reset.
	always_comb begin
		ei           = '0;
		ei.instr     = instr_s1;
		ei.pc        = pc_q;
		if (x_s1 == VF_IDX)   ei.vx = vf_q;
		else if (byp_x_s1)    ei.vx = byp_data_s1;
		else if (vld_x_s1)    ei.vx = vx_mem_s1;
		if (y_s1 == VF_IDX)   ei.vy = vf_q;
		else if (byp_y_s1)    ei.vy = byp_data_s1;
		else if (vld_y_s1)    ei.vy = vy_mem_s1;
		ei.ret_addr  = byp_ret_s1 ? byp_ret_data_s1 : ret_mem_s1;
		ei.stk_full  = (sp_q >= SP_W'(STACK_DEPTH));
		ei.stk_empty = (sp_q == '0);
	end

	c8rab_exec u_exec (
		.ei (ei),
		.eo (eo)
	);

	// ---------------- write-back controls ----------------
	assign reg_we    = s1_adv && eo.res.reg_written && (eo.res.reg_index != VF_IDX);
	assign vf_we     = s1_adv && (eo.res.flag_written ||
	                   (eo.res.reg_written && eo.res.reg_index == VF_IDX));
	assign stk_we    = s1_adv && eo.push;
	assign stk_waddr = sp_q[ADDR_W-1:0];

	// Stack pointer after the word in stage 1; the next read must use it
	always_comb begin
		sp_nxt = sp_q;
		if (eo.push)     sp_nxt = sp_q + SP_W'(1);
		else if (eo.pop) sp_nxt = sp_q - SP_W'(1);
	end

	assign sp_eff    = s1_valid_q ? sp_nxt : sp_q;
	assign sp_eff_m1 = sp_eff - SP_W'(1);
	assign stk_raddr = (sp_eff == '0) ? '0 : sp_eff_m1[ADDR_W-1:0];

	// ---------------- memories ----------------
	always_ff @(posedge clk) begin
		if (reg_we) begin
			reg_mem[eo.res.reg_index] <= eo.res.reg_value;
		end
		if (accept) begin
			vx_mem_s1 <= reg_mem[rd_x];
			vy_mem_s1 <= reg_mem[rd_y];
		end
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_waddr] <= eo.link;
		end
		if (accept) begin
			ret_mem_s1 <= stk_mem[stk_raddr];
		end
	end

	// ---------------- stage 1 payload and bypass ----------------
	always_ff @(posedge clk) begin
		if (accept) begin
			instr_s1        <= instr.instruction;
			vld_x_s1        <= reg_vld_q[rd_x];
			vld_y_s1        <= reg_vld_q[rd_y];
			byp_x_s1        <= reg_we && (eo.res.reg_index == rd_x);
			byp_y_s1        <= reg_we && (eo.res.reg_index == rd_y);
			byp_data_s1     <= eo.res.reg_value;
			byp_ret_s1      <= stk_we && (stk_waddr == stk_raddr);
			byp_ret_data_s1 <= eo.link;
		end
	end

	// ---------------- architectural state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_vld_q <= '0;
			vf_q      <= '0;
			pc_q      <= PC_RESET;
			sp_q      <= '0;
		end else if (s1_adv) begin
			if (reg_we) reg_vld_q[eo.res.reg_index] <= 1'b1;
			if (vf_we) begin
				vf_q <= eo.res.flag_written ? {{(DATA_W-1){1'b0}}, eo.res.flag_value}
				                            : eo.res.reg_value;
			end
			pc_q <= eo.res.next_pc;
			sp_q <= sp_nxt;
		end
	end

	// ---------------- pipeline control ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept)      s1_valid_q <= 1'b1;
			else if (s1_adv) s1_valid_q <= 1'b0;
			if (s1_adv)            out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;
		end
	end

	// Hold the result word until taken
	always_ff @(posedge clk) begin
		if (s1_adv) res_q <= eo.res;
	end

	assign result.valid        = out_valid_q;
	assign result.next_pc      = res_q.next_pc;
	assign result.clear_screen = res_q.clear_screen;
	assign result.unhandled    = res_q.unhandled;
	assign result.stack_fault  = res_q.stack_fault;
	assign result.reg_written  = res_q.reg_written;
	assign result.reg_index    = res_q.reg_index;
	assign result.reg_value    = res_q.reg_value;
	assign result.flag_written = res_q.flag_written;
	assign result.flag_value   = res_q.flag_value;

	// ---------------- assertions ----------------
	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH))
		else $error("stack pointer beyond stack depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		stk_we |-> (sp_q < SP_W'(STACK_DEPTH)))
		else $error("push into a full stack");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s1_valid_q) |-> s1_adv)
		else $error("stage 1 word overwritten before retiring");

	a_pc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_adv |=> $stable(pc_q))
		else $error("PC moved without a retiring word");

endmodule

/* src/c8rab_exec.sv */
// ----------------------------------------------------------------------------
// c8rab_exec
// Decode, ALU and branch resolution of one instruction word.
// ----------------------------------------------------------------------------
module c8rab_exec
	import c8rab_pkg::*;
(
	input  exec_in_t  ei,
	output exec_out_t eo
);

	logic [3:0]        top;
	logic [IDX_W-1:0]  x;
	logic [3:0]        sub;
	logic [DATA_W-1:0] kk;
	logic [PC_W-1:0]   nnn;
	logic [PC_W-1:0]   seq;
	logic [PC_W-1:0]   skp;
	logic [DATA_W:0]   sum;
	logic [DATA_W-1:0] diff;

	assign top  = ei.instr[15:12];
	assign x    = ei.instr[11:8];
	assign sub  = ei.instr[3:0];
	assign kk   = ei.instr[7:0];
	assign nnn  = ei.instr[11:0];
	assign seq  = ei.pc + PC_STEP;
	assign skp  = ei.pc + PC_SKIP;
	assign sum  = {1'b0, ei.vx} + {1'b0, ei.vy};
	assign diff = ei.vx - ei.vy;

	always_comb begin
		eo                  = '0;
		eo.link             = seq;
		eo.res.next_pc      = seq;
		case (op_class_t'(top))
			OP_SYS: begin
				if (ei.instr == INSTR_CLS) begin
					eo.res.clear_screen = 1'b1;
				end else if (ei.instr == INSTR_RET) begin
					if (ei.stk_empty) begin
						eo.res.stack_fault = 1'b1;
					end else begin
						eo.pop         = 1'b1;
						eo.res.next_pc = ei.ret_addr;
					end
				end else begin
					eo.res.next_pc = nnn;
				end
			end
			OP_JP: begin
				eo.res.next_pc = nnn;
			end
			OP_CALL: begin
				if (ei.stk_full) begin
					eo.res.stack_fault = 1'b1;
				end else begin
					eo.push        = 1'b1;
					eo.res.next_pc = nnn;
				end
			end
			OP_SE_IMM: begin
				if (ei.vx == kk) eo.res.next_pc = skp;
			end
			OP_SNE_IMM: begin
				if (ei.vx != kk) eo.res.next_pc = skp;
			end
			OP_SE_REG: begin
				if (sub != SE_REG_SUB) begin
					eo.res.unhandled = 1'b1;
				end else if (ei.vx == ei.vy) begin
					eo.res.next_pc = skp;
				end
			end
			OP_LD_IMM: begin
				eo.res.reg_written = 1'b1;
				eo.res.reg_value   = kk;
			end
			OP_ADD_IMM: begin
				eo.res.reg_written = 1'b1;
				eo.res.reg_value   = ei.vx + kk;
			end
			OP_ALU: begin
				eo.res.reg_written = 1'b1;
				case (alu_op_t'(sub))
					ALU_LD:  eo.res.reg_value = ei.vy;
					ALU_OR:  eo.res.reg_value = ei.vx | ei.vy;
					ALU_AND: eo.res.reg_value = ei.vx & ei.vy;
					ALU_XOR: eo.res.reg_value = ei.vx ^ ei.vy;
					ALU_ADD: begin
						eo.res.reg_value    = sum[DATA_W-1:0];
						eo.res.flag_written = 1'b1;
						eo.res.flag_value   = sum[DATA_W];
					end
					ALU_SUB: begin
						eo.res.reg_value    = diff;
						eo.res.flag_written = 1'b1;
						eo.res.flag_value   = (ei.vx >= ei.vy);
					end
					ALU_SHR: begin
						eo.res.reg_value    = {1'b0, ei.vx[DATA_W-1:1]};
						eo.res.flag_written = 1'b1;
						eo.res.flag_value   = ei.vx[0];
					end
					default: begin
						eo.res.reg_written = 1'b0;
						eo.res.unhandled   = 1'b1;
					end
				endcase
			end
			default: begin
				eo.res.unhandled = 1'b1;
			end
		endcase
		eo.res.reg_index = eo.res.reg_written ? x : '0;
	end

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb - CHIP-8 execute unit bench
// Drives instruction words into the execute unit, tracks registers, PC and
// return stack in a scoreboard, and compares every result word field by field.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import c8rab_pkg::*;

	// Directed words run first, then the randomized stream.
	localparam int RANDOM_WORDS = 750;
	// Words after which the receiver stops dropping ready for a while.
	localparam int STEADY_FROM  = 300;
	localparam int STEADY_UNTIL = 420;
	// Words after which the receiver holds ready low to back up the pipe.
	localparam int HOLD_AFTER   = 500;
	localparam int HOLD_CYCLES  = 80;
	// Idle percentage on both sides outside the steady stretch.
	localparam int IDLE_PCT     = 19;
	// Cycles with no word moving on either side before the run is abandoned.
	localparam int STALL_LIMIT  = 2000;
	// Cycles to let pass after the last result so stray words show up.
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_REPORTS  = 40;

	// ------------------------------------------------------------------------
	// Scoreboard: tracks the architectural state of the unit, predicts the
	// result of each accepted instruction word and checks results in order.
	// ------------------------------------------------------------------------
	class chip8_exec_scoreboard;
		logic [DATA_W-1:0] regs [NUM_REGS];
		logic [PC_W-1:0]   pc;
		int                depth;
		logic [PC_W-1:0]   ret_stack [STACK_DEPTH_DEF];
		result_t           awaited_results [$];

		int errors;
		int checked;
		int words;
		int calls;
		int returns;
		int faults;
		int skips;
		int unhandled;
		int flag_writes;

		function new();
			foreach (regs[i]) regs[i] = '0;
			foreach (ret_stack[i]) ret_stack[i] = '0;
			pc = PC_RESET;
			depth = 0;
			errors = 0;
			checked = 0;
			words = 0;
			calls = 0;
			returns = 0;
			faults = 0;
			skips = 0;
			unhandled = 0;
			flag_writes = 0;
		endfunction

		task report(input string msg);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t ns: MISMATCH %s", $realtime, msg);
		endtask

		// Execute one accepted instruction word against the tracked state and
		// queue the result it must produce.
		function void execute_word(input logic [INSTR_W-1:0] w);
			result_t           r;
			logic [IDX_W-1:0]  x;
			logic [IDX_W-1:0]  y;
			logic [3:0]        sub;
			logic [DATA_W-1:0] kk;
			logic [DATA_W-1:0] vx;
			logic [DATA_W-1:0] vy;
			logic [PC_W-1:0]   nnn;
			logic [PC_W-1:0]   seq;
			logic [PC_W-1:0]   skip_pc;
			logic [DATA_W:0]   sum;

			x = w[11:8];
			y = w[7:4];
			sub = w[3:0];
			kk = w[7:0];
			nnn = w[PC_W-1:0];
			vx = regs[x];
			vy = regs[y];
			seq = pc + PC_STEP;
			skip_pc = pc + PC_SKIP;
			r = '0;
			r.next_pc = seq;

			case (w[15:12])
				OP_SYS: begin
					if (w == INSTR_CLS) begin
						r.clear_screen = 1'b1;
					end else if (w == INSTR_RET) begin
						if (depth == 0) begin
							r.stack_fault = 1'b1;
						end else begin
							depth--;
							r.next_pc = ret_stack[depth];
							returns++;
						end
					end else begin
						r.next_pc = nnn;
					end
				end
				OP_JP: r.next_pc = nnn;
				OP_CALL: begin
					if (depth >= STACK_DEPTH_DEF) begin
						r.stack_fault = 1'b1;
					end else begin
						ret_stack[depth] = seq;
						depth++;
						r.next_pc = nnn;
						calls++;
					end
				end
				OP_SE_IMM: if (vx == kk) r.next_pc = skip_pc;
				OP_SNE_IMM: if (vx != kk) r.next_pc = skip_pc;
				OP_SE_REG: begin
					if (sub != SE_REG_SUB)
						r.unhandled = 1'b1;
					else if (vx == vy)
						r.next_pc = skip_pc;
				end
				OP_LD_IMM: begin
					r.reg_written = 1'b1;
					r.reg_value = kk;
				end
				OP_ADD_IMM: begin
					// wraps, VF untouched
					r.reg_written = 1'b1;
					r.reg_value = vx + kk;
				end
				OP_ALU: begin
					r.reg_written = 1'b1;
					case (sub)
						ALU_LD:  r.reg_value = vy;
						ALU_OR:  r.reg_value = vx | vy;
						ALU_AND: r.reg_value = vx & vy;
						ALU_XOR: r.reg_value = vx ^ vy;
						ALU_ADD: begin
							sum = {1'b0, vx} + {1'b0, vy};
							r.reg_value = sum[DATA_W-1:0];
							r.flag_written = 1'b1;
							r.flag_value = sum[DATA_W];
						end
						ALU_SUB: begin
							// flag means no borrow
							r.reg_value = vx - vy;
							r.flag_written = 1'b1;
							r.flag_value = (vx >= vy);
						end
						ALU_SHR: begin
							r.reg_value = vx >> 1;
							r.flag_written = 1'b1;
							r.flag_value = vx[0];
						end
						default: begin
							r.reg_written = 1'b0;
							r.unhandled = 1'b1;
						end
					endcase
				end
				default: r.unhandled = 1'b1;
			endcase

			// Vx first, then VF: the flag wins when x is VF.
			if (r.reg_written) begin
				r.reg_index = x;
				regs[x] = r.reg_value;
			end
			if (r.flag_written) begin
				regs[VF_IDX] = {{(DATA_W-1){1'b0}}, r.flag_value};
				flag_writes++;
			end
			if (r.stack_fault) faults++;
			if (r.unhandled) unhandled++;
			if (r.next_pc == skip_pc && w[15:12] inside {OP_SE_IMM, OP_SNE_IMM, OP_SE_REG})
				skips++;
			pc = r.next_pc;
			words++;
			awaited_results.push_back(r);
		endfunction

		task check_field(input string name, input logic [15:0] got, input logic [15:0] want);
			if (got !== want)
				report($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
					checked, name, got, want));
		endtask

		task compare_result(input result_t got);
			result_t want;
			if (awaited_results.size() == 0) begin
				report($sformatf("unexpected result word, next_pc 0x%0h", got.next_pc));
			end else begin
				want = awaited_results.pop_front();
				check_field("next_pc", 16'(got.next_pc), 16'(want.next_pc));
				check_field("clear_screen", 16'(got.clear_screen),
					16'(want.clear_screen));
				check_field("unhandled", 16'(got.unhandled), 16'(want.unhandled));
				check_field("stack_fault", 16'(got.stack_fault),
					16'(want.stack_fault));
				check_field("reg_written", 16'(got.reg_written),
					16'(want.reg_written));
				check_field("reg_index", 16'(got.reg_index), 16'(want.reg_index));
				check_field("reg_value", 16'(got.reg_value), 16'(want.reg_value));
				check_field("flag_written", 16'(got.flag_written),
					16'(want.flag_written));
				check_field("flag_value", 16'(got.flag_value),
					16'(want.flag_value));
				checked++;
			end
		endtask

		function int outstanding();
			return awaited_results.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, channels and the unit
	// ------------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	c8rab_instr_if  instr_ch ();
	c8rab_result_if result_ch ();

	chip8_register_alu_branch_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.instr  (instr_ch),
		.result (result_ch)
	);

	chip8_exec_scoreboard sb = new();

	// steady and hold_req are shared between the sender and the receiver process.
	bit steady;     // suppress idling on both sides
	bit hold_req;   // ask the receiver for one long hold-off
	int quiet_cycles;

	// ------------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------------

	// Offer one instruction word and return at the edge that accepts it. The
	// scoreboard is updated here, at acceptance, so the next generated word
	// already sees the new register values.
	task automatic send_word(input logic [INSTR_W-1:0] w);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			instr_ch.valid <= 1'b0;
			@(posedge clk);
		end
		instr_ch.valid <= 1'b1;
		instr_ch.instruction <= w;
		@(posedge clk);
		while (!instr_ch.ready) @(posedge clk);
		sb.execute_word(w);
	endtask

	// Build one random instruction word. Most words are well-formed opcodes
	// with random operands; a share is raw noise to cover every bit pattern.
	function automatic logic [INSTR_W-1:0] gen_word();
		int unsigned       roll;
		logic [IDX_W-1:0]  x;
		logic [IDX_W-1:0]  y;
		logic [DATA_W-1:0] kk;
		logic [3:0]        sub;
		logic [PC_W-1:0]   nnn;

		roll = $urandom_range(99);
		x = IDX_W'($urandom_range(NUM_REGS - 1));
		y = IDX_W'($urandom_range(NUM_REGS - 1));
		kk = DATA_W'($urandom_range(255));
		nnn = PC_W'($urandom_range(4095));
		// Bias toward the immediate and ALU ops that feed the compares.
		if (roll < 10)
			return INSTR_W'($urandom_range(16'hFFFF));
		if (roll < 18)
			return {OP_CALL, nnn};
		if (roll < 26)
			return INSTR_RET;
		if (roll < 29)
			return INSTR_CLS;
		if (roll < 34)
			return {($urandom_range(1) ? OP_JP : OP_SYS), nnn};
		if (roll < 46) begin
			// hit the taken side of the compare about half the time
			if ($urandom_range(1)) kk = sb.regs[x];
			return {($urandom_range(1) ? OP_SE_IMM : OP_SNE_IMM), x, kk};
		end
		if (roll < 52) begin
			sub = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : SE_REG_SUB;
			if ($urandom_range(1)) y = x;
			return {OP_SE_REG, x, y, sub};
		end
		if (roll < 64)
			return {OP_LD_IMM, x, kk};
		if (roll < 72)
			return {OP_ADD_IMM, x, kk};
		// ALU group: mostly supported sub-ops, sometimes the unsupported ones
		sub = ($urandom_range(4) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(6));
		return {OP_ALU, x, y, sub};
	endfunction

	// ------------------------------------------------------------------------
	// Main sequence: reset, directed words, randomized words, drain, verdict
	// ------------------------------------------------------------------------
	initial begin : run_program
		logic [INSTR_W-1:0] directed [$];
		int                 sent;
		int                 burst;
		int unsigned        roll;
		bit                 hold_done;

		arst_n = 1'b0;
		instr_ch.valid <= 1'b0;
		instr_ch.instruction <= '0;
		steady = 1'b0;
		hold_req = 1'b0;
		hold_done = 1'b0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Comments give the state the word meets.
		directed = {
			INSTR_CLS,              // clear request
			INSTR_RET,              // return with empty stack: fault
			16'h60FF, 16'h6101,     // V0 = FF, V1 = 01
			16'h8014,               // add with carry out
			16'h60FF, 16'h7002,     // add immediate wraps, VF untouched
			16'h6255, 16'h63AA,
			16'h8231, 16'h8232, 16'h8233,   // or, and, xor
			16'h8215,               // subtract with borrow: flag 0
			16'h8016,               // shift right, bit 0 to VF
			16'h8F34,               // VF as target of add: flag wins
			16'h8F06,               // VF as target of shift
			16'h8237, 16'h823F,     // unsupported ALU sub-ops
			16'h5231,               // register compare, nonzero low nibble
			16'h5230,               // register compare, not equal
			16'h33AA, 16'h43AA,     // immediate compares, taken and not
			16'h9123, 16'hF0FF,     // unsupported classes
			16'h2ABC, INSTR_RET,    // call and return
			16'h0345, 16'h1FFE,     // machine jump, jump to top of memory
			16'h3000,               // skip from the top wraps the PC
			16'h0000                // machine jump to address zero
		};
		foreach (directed[i]) send_word(directed[i]);

		// Randomized part. Bursts of calls and returns drive the stack past
		// both ends; the rest is single random words.
		sent = 0;
		while (sent < RANDOM_WORDS) begin
			steady = (sent >= STEADY_FROM && sent < STEADY_UNTIL);
			if (!hold_done && sent >= HOLD_AFTER) begin
				hold_req = 1'b1;
				hold_done = 1'b1;
			end
			roll = $urandom_range(99);
			if (roll < 4) begin
				burst = $urandom_range(STACK_DEPTH_DEF + 2, 4);
				repeat (burst) send_word({OP_CALL, 12'($urandom_range(4095))});
				sent += burst;
			end else if (roll < 7) begin
				burst = $urandom_range(STACK_DEPTH_DEF + 2, 4);
				repeat (burst) send_word(INSTR_RET);
				sent += burst;
			end else begin
				send_word(gen_word());
				sent++;
			end
		end
		steady = 1'b0;
		instr_ch.valid <= 1'b0;

		// Wait for every awaited result; the watchdog bounds this loop.
		while (sb.outstanding() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.outstanding() > 0)
			sb.report($sformatf("%0d result words never arrived", sb.outstanding()));

		$display("Ran %0d instruction words, checked %0d result words, %0d mismatches.",
			sb.words, sb.checked, sb.errors);
		$display("Covered %0d calls, %0d returns, %0d stack faults, %0d skips,",
			sb.calls, sb.returns, sb.faults, sb.skips);
		$display("  %0d unhandled words and %0d VF writes.",
			sb.unhandled, sb.flag_writes);
		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Receiver side: random ready, a steady stretch, and one long hold-off
	// that fills the unit and stalls its input.
	// ------------------------------------------------------------------------
	initial begin : drain_results
		int hold_left;

		hold_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Check each accepted result word against the oldest prediction.
	always @(posedge clk) begin : take_result
		result_t got;

		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.next_pc      = result_ch.next_pc;
			got.clear_screen = result_ch.clear_screen;
			got.unhandled    = result_ch.unhandled;
			got.stack_fault  = result_ch.stack_fault;
			got.reg_written  = result_ch.reg_written;
			got.reg_index    = result_ch.reg_index;
			got.reg_value    = result_ch.reg_value;
			got.flag_written = result_ch.flag_written;
			got.flag_value   = result_ch.flag_value;
			sb.compare_result(got);
		end
	end

	// Watchdog: abandon the run when no word moves for too long.
	initial quiet_cycles = 0;

	always @(posedge clk) begin
		if ((instr_ch.valid && instr_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Timeout: no word moved for %0d cycles, %0d results outstanding",
				STALL_LIMIT, sb.outstanding());
			$display("Verification failed");
			$finish;
		end
	end

endmodule

/* chip8_register_alu_branch_unit.f */
src/c8rab_pkg.sv
src/c8rab_if.sv
src/c8rab_exec.sv
src/chip8_register_alu_branch_unit.sv
bench/tb.sv
